// File: src/mlt_pkg.sv
package mlt_pkg;

    // Field widths of one word
    localparam int MAC_W   = 48;
    localparam int PORT_W  = 8;
    localparam int STAMP_W = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 13;
    localparam int AGE_W   = 12;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LEARN   = 3'd0;
    localparam logic [OP_W-1:0] OP_RESOLVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SWEEP   = 3'd2;
    localparam logic [OP_W-1:0] OP_DETACH  = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

    // Learn status codes
    localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFRESHED = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_MOVED     = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    // Configuration register indexes
    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic REG_MAX_AGE     = 1'b1;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 13'd100;
    localparam logic [AGE_W-1:0] MAX_AGE_RST     = 12'd240;

    // One table entry as stored in memory
    typedef struct packed {
        logic               valid;
        logic [MAC_W-1:0]   mac;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;        // latch accepted word
        logic clr_step;    // clear one entry after reset
        logic scan_start;  // begin a pass over the table
        logic commit;      // final write and result load
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic clr_last;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: src/mlt_ram.sv
module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/mlt_ctrl.sv
module mlt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mlt_pkg::t_sts i_sts,
    output mlt_pkg::t_cmd o_cmd
);
    import mlt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.need_scan) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: src/mlt_datapath.sv
module mlt_datapath #(
    parameter int ENTRIES = 4096,
    parameter int PORTS   = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mlt_pkg::t_cmd                i_cmd,
    output mlt_pkg::t_sts                o_sts,
    input  logic [mlt_pkg::OP_W-1:0]     i_op,
    input  logic [mlt_pkg::MAC_W-1:0]    i_mac,
    input  logic [mlt_pkg::PORT_W-1:0]   i_port,
    input  logic [mlt_pkg::STAMP_W-1:0]  i_now,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [mlt_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_hit,
    output logic [mlt_pkg::PORT_W-1:0]   o_out_port,
    output logic [mlt_pkg::STAT_W-1:0]   o_learn_status,
    output logic [mlt_pkg::CNT_W-1:0]    o_removed,
    output logic [mlt_pkg::CNT_W-1:0]    o_entry_count
);
    import mlt_pkg::*;

    localparam int AW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int CMW = ((CW > CNT_W) ? CW : CNT_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    // Configuration
    logic [CNT_W-1:0] r_max_entries;
    logic [AGE_W-1:0] r_max_age;

    // Accepted word
    logic [OP_W-1:0]    r_op;
    logic [MAC_W-1:0]   r_mac;
    logic [PORT_W-1:0]  r_port;
    logic [STAMP_W-1:0] r_now;

    // Scan pipeline
    logic [AW-1:0] r_addr;
    logic          r_busy;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic [AW-1:0] r_rd_idx;

    // Scan results
    logic               r_found;
    logic [AW-1:0]      r_found_idx;
    logic [PORT_W-1:0]  r_found_port;
    logic [STAMP_W-1:0] r_found_stamp;
    logic               r_free;
    logic [AW-1:0]      r_free_idx;
    logic [CW-1:0]      r_removed;
    logic [CW-1:0]      r_count;

    // Result register
    logic               r_out_vld;
    logic               r_hit;
    logic [PORT_W-1:0]  r_oport;
    logic [STAT_W-1:0]  r_status;
    logic [CNT_W-1:0]   r_rem_out;
    logic [CNT_W-1:0]   r_cnt_out;

    t_entry        rd_entry, wr_entry, c_entry;
    logic          wr_en, c_we, kill, in_learn_ok, learn_ok, need_scan;
    logic [AW-1:0] wr_addr, c_waddr;
    logic [STAT_W-1:0] c_status;
    logic          c_hit;
    logic [PORT_W-1:0] c_oport;
    logic [CW-1:0] c_count;
    logic [STAMP_W-1:0] rd_age, found_age;

    // Learn qualifies: unicast, nonzero, port in range
    assign in_learn_ok = !i_mac[40] && (i_mac != '0)
                       && ({1'b0, i_port} < (PORT_W + 1)'(PORTS));
    assign learn_ok    = (r_op == OP_LEARN) && !r_mac[40] && (r_mac != '0)
                       && ({1'b0, r_port} < (PORT_W + 1)'(PORTS));

    // Operations that walk the table
    always_comb begin
        unique case (i_op) inside
            OP_LEARN:                                  need_scan = in_learn_ok;
            OP_RESOLVE, OP_SWEEP, OP_DETACH, OP_FLUSH: need_scan = 1'b1;
            default:                                   need_scan = 1'b0;
        endcase
    end
    assign o_sts.need_scan = need_scan;
    assign o_sts.clr_last  = (r_addr == LAST);
    assign o_sts.scan_done = r_rd_vld && r_rd_last;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Removal test for bulk operations
    assign rd_age = r_now - rd_entry.stamp;
    always_comb begin
        case (r_op)
            OP_SWEEP:  kill = rd_age >= STAMP_W'(r_max_age);
            OP_DETACH: kill = rd_entry.port == r_port;
            OP_FLUSH:  kill = 1'b1;
            default:   kill = 1'b0;
        endcase
        kill = kill && rd_entry.valid && r_rd_vld;
    end

    // Final learn write and result fields
    assign found_age = r_now - r_found_stamp;
    always_comb begin
        c_status = ST_IGNORED;
        c_hit    = 1'b0;
        c_oport  = '0;
        c_we     = 1'b0;
        c_waddr  = r_found_idx;
        c_count  = r_count;
        c_entry  = '{valid: 1'b1, mac: r_mac, port: r_port, stamp: r_now};
        if (learn_ok) begin
            if (r_found) begin
                c_we = 1'b1;
                if (r_found_port == r_port) begin
                    c_status = ST_REFRESHED;
                end else if (CMW'(r_count) > CMW'(r_max_entries)) begin
                    c_status     = ST_FULL;
                    c_entry.port = r_found_port;
                end else begin
                    c_status = ST_MOVED;
                end
            end else if (CMW'(r_count) + CMW'(1) > CMW'(r_max_entries)) begin
                c_status = ST_FULL;
            end else if (r_free) begin
                c_we     = 1'b1;
                c_waddr  = r_free_idx;
                c_count  = r_count + CW'(1);
                c_status = ST_INSERTED;
            end else begin
                c_status = ST_FULL;
            end
        end else if (r_op == OP_RESOLVE) begin
            if (r_found && (found_age <= STAMP_W'(r_max_age))) begin
                c_hit   = 1'b1;
                c_oport = r_found_port;
            end
        end
    end

    // Memory write mux: clear pass, removal, learn commit
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_rd_idx;
        wr_entry = rd_entry;
        wr_entry.valid = 1'b0;
        if (i_cmd.clr_step) begin
            wr_en    = 1'b1;
            wr_addr  = r_addr;
            wr_entry = '0;
        end else if (kill) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit && c_we) begin
            wr_en    = 1'b1;
            wr_addr  = c_waddr;
            wr_entry = c_entry;
        end
    end

    mlt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_entry),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= MAX_ENTRIES_RST;
            r_max_age     <= MAX_AGE_RST;
            r_addr        <= '0;
            r_busy        <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_rd_last     <= 1'b0;
            r_count       <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_ENTRIES: r_max_entries <= i_cfg_data;
                    REG_MAX_AGE:     r_max_age     <= i_cfg_data[AGE_W-1:0];
                    default:         ;
                endcase
            end
            r_rd_vld  <= r_busy;
            r_rd_last <= r_busy && (r_addr == LAST);
            if (i_cmd.scan_start) begin
                r_addr <= '0;
                r_busy <= 1'b1;
            end else if (r_busy || i_cmd.clr_step) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + AW'(1);
                if (r_addr == LAST) r_busy <= 1'b0;
            end
            if (kill) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.commit) begin
                r_count <= c_count;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_mac  <= i_mac;
            r_port <= i_port;
            r_now  <= i_now;
        end
        if (i_cmd.scan_start) begin
            r_found   <= 1'b0;
            r_free    <= 1'b0;
            r_removed <= '0;
        end else if (r_rd_vld) begin
            if (rd_entry.valid && (rd_entry.mac == r_mac) && !r_found) begin
                r_found       <= 1'b1;
                r_found_idx   <= r_rd_idx;
                r_found_port  <= rd_entry.port;
                r_found_stamp <= rd_entry.stamp;
            end
            if (!rd_entry.valid && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (kill) r_removed <= r_removed + CW'(1);
        end else if (i_cmd.load) begin
            r_found   <= 1'b0;
            r_free    <= 1'b0;
            r_removed <= '0;
        end
        if (i_cmd.commit) begin
            r_hit     <= c_hit;
            r_oport   <= c_oport;
            r_status  <= c_status;
            r_rem_out <= CNT_W'(r_removed);
            r_cnt_out <= CNT_W'(c_count);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_hit          = r_hit;
    assign o_out_port     = r_oport;
    assign o_learn_status = r_status;
    assign o_removed      = r_rem_out;
    assign o_entry_count  = r_cnt_out;
endmodule

// File: src/mac_learning_table.sv
// Learning bridge address table with aging.
// Input words arrive on the s_axis channel: tuser carries the operation
// (learn, resolve, age sweep, detach port, flush), tdata the address, port
// and current time. Each word gives exactly one result word on m_axis.
// Every operation except an ignored learn or an unknown code walks the whole
// table in one memory, one entry per cycle through the registered read port;
// an ignored learn or an unknown code skips the walk. One word is in work at
// a time.
// A finished result sits in an output register; while the receiver stalls
// the block still accepts the next word and works on it, and holds its
// result until the output register is free.
// After reset the table is cleared by a pass over all ENTRIES entries, during
// which s_axis_tready stays low. Configuration writes (max_entries, max_age) are
// taken at any cycle through the cfg port and should be made while idle.
module mac_learning_table #(
    parameter int ENTRIES = 4096,
    parameter int PORTS   = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,   // mac_addr[47:0], port[55:48], now[87:56]
    input  logic [2:0]   s_axis_tuser,   // operation[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // hit[0], out_port[8:1], learn_status[11:9],
                                         // removed[24:12], entry_count[37:25], zero[39:38]
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [12:0]  i_cfg_data
);
    import mlt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic               hit;
    logic [PORT_W-1:0]  out_port;
    logic [STAT_W-1:0]  learn_status;
    logic [CNT_W-1:0]   removed;
    logic [CNT_W-1:0]   entry_count;

    mlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mlt_datapath #(
        .ENTRIES (ENTRIES),
        .PORTS   (PORTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (s_axis_tuser),
        .i_mac          (s_axis_tdata[47:0]),
        .i_port         (s_axis_tdata[55:48]),
        .i_now          (s_axis_tdata[87:56]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_hit          (hit),
        .o_out_port     (out_port),
        .o_learn_status (learn_status),
        .o_removed      (removed),
        .o_entry_count  (entry_count)
    );

    assign m_axis_tdata = {2'b00, entry_count, removed, learn_status, out_port, hit};
endmodule
